[rtl/iir_lowpass_order5_defines.svh]
// ----------------------------------------------------------------------------
// iir_lowpass_order5 assertion macros
// concurrent assertion wrappers, empty bodies under synthesis
// ----------------------------------------------------------------------------
`ifndef IIR_LOWPASS_ORDER5_DEFINES_SVH
`define IIR_LOWPASS_ORDER5_DEFINES_SVH

`ifndef SYNTHESIS
`define IIR_LP5_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iir_lp5 assertion failed");
`define IIR_LP5_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("iir_lp5 forbidden condition");
`else
`define IIR_LP5_ASSERT(label, clk, rst_n, prop)
`define IIR_LP5_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/iir_lp5_pkg.sv]
// ----------------------------------------------------------------------------
// iir_lp5_pkg
// shared widths, types and fixed-point constants of the order-5 low-pass filter
// ----------------------------------------------------------------------------
package iir_lp5_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int HIST_FRAC_DEF    = 24;

    localparam int TAPS       = 5;
    localparam int HIST_W     = 48;
    localparam int OUT_W      = 32;
    localparam int SPLIT_BITS = 24;
    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 28;
    localparam int GAIN_W     = 29;
    localparam int GAIN_FRAC  = 40;

    // feedback accumulator and result widths
    localparam int FB_ACC_W = 60;
    localparam int FB_W     = 61;

    // feedforward result grows by this many bits over the sample width
    localparam int FF_GROW = 6 + GAIN_W;

    typedef logic signed [HIST_W-1:0] hist_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // inverse gain, unsigned q0.40 held as a positive signed value
    localparam logic signed [GAIN_W-1:0] INV_GAIN = 29'sd65746156;

    // feedback coefficients q4.28, newest output first
    localparam coef_t FB_COEF [TAPS] = '{
        32'sd1069592649,
        -32'sd1727346482,
        32'sd1410256584,
        -32'sd581198440,
        32'sd96617503
    };

endpackage

[rtl/iir_lp5_ff.sv]
// ----------------------------------------------------------------------------
// iir_lp5_ff
// binomial feedforward sum of the input history scaled by the inverse gain
// ----------------------------------------------------------------------------
module iir_lp5_ff #(
    parameter int SAMPLE_WIDTH      = iir_lp5_pkg::SAMPLE_WIDTH_DEF,
    parameter int HISTORY_FRAC_BITS = iir_lp5_pkg::HIST_FRAC_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0]                        x_new,
    input  logic signed [SAMPLE_WIDTH-1:0]                        x_hist [iir_lp5_pkg::TAPS],
    output logic signed [SAMPLE_WIDTH+iir_lp5_pkg::FF_GROW-1:0]   ff
);

    localparam int SUM_W  = SAMPLE_WIDTH + 6;
    localparam int PROD_W = SAMPLE_WIDTH + iir_lp5_pkg::FF_GROW;
    localparam int SHIFT  = iir_lp5_pkg::GAIN_FRAC - HISTORY_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] FF_HALF = PROD_W'(1) << (SHIFT - 1);

    logic signed [SUM_W-1:0]  x_e;
    logic signed [SUM_W-1:0]  h0;
    logic signed [SUM_W-1:0]  h1;
    logic signed [SUM_W-1:0]  h2;
    logic signed [SUM_W-1:0]  h3;
    logic signed [SUM_W-1:0]  h4;
    logic signed [SUM_W-1:0]  pair5;
    logic signed [SUM_W-1:0]  pair10;
    logic signed [SUM_W-1:0]  ffsum;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;

    assign x_e = SUM_W'(x_new);
    assign h0  = SUM_W'(x_hist[0]);
    assign h1  = SUM_W'(x_hist[1]);
    assign h2  = SUM_W'(x_hist[2]);
    assign h3  = SUM_W'(x_hist[3]);
    assign h4  = SUM_W'(x_hist[4]);

    assign pair5  = h0 + h3;
    assign pair10 = h1 + h2;

    // times 5 and times 10 as shift and add
    assign ffsum = (x_e + h4) + ((pair5 <<< 2) + pair5) + ((pair10 <<< 3) + (pair10 <<< 1));

    assign prod = ffsum * iir_lp5_pkg::INV_GAIN;
    assign rnd  = prod + FF_HALF;
    assign ff   = rnd >>> SHIFT;

endmodule

[rtl/iir_lp5_fb.sv]
// ----------------------------------------------------------------------------
// iir_lp5_fb
// feedback sum of five coefficients times the output history, split products
// ----------------------------------------------------------------------------
module iir_lp5_fb (
    input  iir_lp5_pkg::hist_t                     y_hist [iir_lp5_pkg::TAPS],
    output logic signed [iir_lp5_pkg::FB_W-1:0]    fb
);

    localparam int TAPS   = iir_lp5_pkg::TAPS;
    localparam int SPLIT  = iir_lp5_pkg::SPLIT_BITS;
    localparam int HIST_W = iir_lp5_pkg::HIST_W;
    localparam int COEF_W = iir_lp5_pkg::COEF_W;
    localparam int ACC_W  = iir_lp5_pkg::FB_ACC_W;
    localparam int FB_W   = iir_lp5_pkg::FB_W;
    localparam int HI_W   = HIST_W - SPLIT;
    localparam int PH_W   = COEF_W + HI_W;
    localparam int PL_W   = COEF_W + SPLIT + 1;
    localparam int SHIFT  = iir_lp5_pkg::COEF_FRAC - SPLIT;
    localparam logic signed [FB_W-1:0] FB_HALF = FB_W'(1) << (SHIFT - 1);

    logic signed [HI_W-1:0]  yh [TAPS];
    logic signed [SPLIT:0]   yl [TAPS];
    logic signed [PH_W-1:0]  ph [TAPS];
    logic signed [PL_W-1:0]  pl [TAPS];
    logic signed [ACC_W-1:0] hi_sum;
    logic signed [ACC_W-1:0] lo_sum;
    logic signed [FB_W-1:0]  s;

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            yh[i] = y_hist[i][HIST_W-1:SPLIT];
            yl[i] = $signed({1'b0, y_hist[i][SPLIT-1:0]});
            ph[i] = iir_lp5_pkg::FB_COEF[i] * yh[i];
            pl[i] = iir_lp5_pkg::FB_COEF[i] * yl[i];
        end
    end

    assign hi_sum = (ACC_W'(ph[0]) + ACC_W'(ph[1])) + (ACC_W'(ph[2]) + ACC_W'(ph[3]))
                  + ACC_W'(ph[4]);
    assign lo_sum = (ACC_W'(pl[0]) + ACC_W'(pl[1])) + (ACC_W'(pl[2]) + ACC_W'(pl[3]))
                  + ACC_W'(pl[4]);

    assign s  = FB_W'(hi_sum) + FB_W'(lo_sum >>> SPLIT);
    assign fb = (s + FB_HALF) >>> SHIFT;

endmodule

[rtl/iir_lowpass_order5.sv]
// ----------------------------------------------------------------------------
// iir_lowpass_order5
// fifth-order butterworth low-pass iir filter, fixed point, while the output is not stalled one sample a cycle
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_ready carries sample_in, a signed sample
//   output channel out_valid / out_ready carries filtered_out, signed with
//   8 fractional bits, saturated at the 32-bit limits, one per sample
//   a request is moved at a clock edge with valid and ready both high
//   a taken sample waits in the input register, then its result is registered
//   throughput: one sample per cycle while the receiver does not stall; the
//   output history recurrence is closed combinationally through the five
//   feedback multiplies and the adder tree between the input and output registers
//   reset clears the input and output histories and the valid flags of both registers
//   when the receiver stalls the output register holds its result, the input
//   register still takes one more sample if it is empty, then in_ready drops
//   until the result is taken
// ----------------------------------------------------------------------------
`include "iir_lowpass_order5_defines.svh"

module iir_lowpass_order5 #(
    parameter int SAMPLE_WIDTH      = iir_lp5_pkg::SAMPLE_WIDTH_DEF,
    parameter int HISTORY_FRAC_BITS = iir_lp5_pkg::HIST_FRAC_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iir_lp5_pkg::OUT_W-1:0]   filtered_out
);

    localparam int TAPS   = iir_lp5_pkg::TAPS;
    localparam int HIST_W = iir_lp5_pkg::HIST_W;
    localparam int OUT_W  = iir_lp5_pkg::OUT_W;
    localparam int FF_W   = SAMPLE_WIDTH + iir_lp5_pkg::FF_GROW;
    localparam int FB_W   = iir_lp5_pkg::FB_W;
    localparam int SUM_W  = ((FF_W > FB_W) ? FF_W : FB_W) + 1;
    localparam int ORND_W = HIST_W + 1;
    localparam int O_SHIFT = HISTORY_FRAC_BITS - 8;

    localparam logic signed [SUM_W-1:0] HIST_MAX = SUM_W'({1'b0, {(HIST_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic signed [ORND_W-1:0] OUT_MAX = ORND_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [ORND_W-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic signed [ORND_W-1:0] O_HALF  = ORND_W'(1) << (O_SHIFT - 1);

    logic                            in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_reg;
    logic                            out_valid_reg;
    logic signed [OUT_W-1:0]         filtered_reg;
    logic signed [SAMPLE_WIDTH-1:0]  x_hist_reg [TAPS];
    iir_lp5_pkg::hist_t              y_hist_reg [TAPS];

    logic                            fire;
    logic signed [FF_W-1:0]          ff;
    logic signed [FB_W-1:0]          fb;
    logic signed [SUM_W-1:0]         y_sum;
    logic signed [SUM_W-1:0]         y_sat;
    iir_lp5_pkg::hist_t              y_new;
    logic signed [ORND_W-1:0]        o_rnd;
    logic signed [ORND_W-1:0]        o_sh;
    logic signed [OUT_W-1:0]         filtered_next;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    iir_lp5_ff #(
        .SAMPLE_WIDTH      (SAMPLE_WIDTH),
        .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
    ) u_ff (
        .x_new  (sample_reg),
        .x_hist (x_hist_reg),
        .ff     (ff)
    );

    iir_lp5_fb u_fb (
        .y_hist (y_hist_reg),
        .fb     (fb)
    );

    always_comb
    begin
        y_sum = SUM_W'(ff) + SUM_W'(fb);
        if (y_sum > HIST_MAX)
        begin
            y_sat = HIST_MAX;
        end
        else if (y_sum < HIST_MIN)
        begin
            y_sat = HIST_MIN;
        end
        else
        begin
            y_sat = y_sum;
        end
        y_new = HIST_W'(y_sat);
        o_rnd = ORND_W'(y_new) + O_HALF;
        o_sh  = o_rnd >>> O_SHIFT;
        if (o_sh > OUT_MAX)
        begin
            filtered_next = OUT_W'(OUT_MAX);
        end
        else if (o_sh < OUT_MIN)
        begin
            filtered_next = OUT_W'(OUT_MIN);
        end
        else
        begin
            filtered_next = OUT_W'(o_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                x_hist_reg[0] <= sample_reg;
                y_hist_reg[0] <= y_new;
                for (int i = 1; i < TAPS; i++)
                begin
                    x_hist_reg[i] <= x_hist_reg[i-1];
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample_in;
        end
        if (fire)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered_out = filtered_reg;

    `IIR_LP5_ASSERT(a_fire_loads_out, clk, rst_n, fire |=> out_valid_reg)
    `IIR_LP5_ASSERT(a_x_hist_shift, clk, rst_n, fire |=> (x_hist_reg[0] == $past(sample_reg)))
    `IIR_LP5_ASSERT(a_y_hist_shift, clk, rst_n, fire |=> (y_hist_reg[1] == $past(y_hist_reg[0])))
    `IIR_LP5_ASSERT(a_hold_pending, clk, rst_n,
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(sample_reg)))
    `IIR_LP5_ASSERT_NEVER(a_no_fire_on_stall, clk, rst_n, fire && out_valid_reg && !out_ready)

endmodule
